[rtl/core/gmv_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gmv_pkg: grant message validator shared definitions
// Default sizes, region and error codes, character codes and channel payloads.
// ----------------------------------------------------------------------------
package gmv_pkg;

  // Default message layout
  localparam int unsigned TICKET_BYTES_DEF   = 32;
  localparam int unsigned HEADER_BYTES_DEF   = 68;
  localparam int unsigned ROUTE_HOST_MAX_DEF = 253;
  localparam int unsigned TLS_HOST_MAX_DEF   = 253;
  localparam int unsigned AUDIENCE_MAX_DEF   = 64;
  localparam int unsigned MESSAGE_MAX_DEF    = 1024;

  // Fixed layout points and limits
  localparam int unsigned CNT_W        = 11;
  localparam int unsigned POS_W        = 12;
  localparam logic [CNT_W-1:0] COUNT_TOP = 11'd2047;
  localparam logic [6:0]  LABEL_TOP    = 7'd63;
  localparam int unsigned GRANT_START  = 20;
  localparam int unsigned TICKET_START = 36;

  // Region tags
  localparam logic [3:0] RGN_HEAD     = 4'd0;
  localparam logic [3:0] RGN_PORTS    = 4'd1;
  localparam logic [3:0] RGN_EXPIRY   = 4'd2;
  localparam logic [3:0] RGN_GRANT    = 4'd3;
  localparam logic [3:0] RGN_TICKET   = 4'd4;
  localparam logic [3:0] RGN_PAD      = 4'd5;
  localparam logic [3:0] RGN_ROUTE    = 4'd6;
  localparam logic [3:0] RGN_TLS      = 4'd7;
  localparam logic [3:0] RGN_AUDIENCE = 4'd8;
  localparam logic [3:0] RGN_EXCESS   = 4'd9;

  // Error codes
  localparam logic [3:0] ERR_OK        = 4'd0;
  localparam logic [3:0] ERR_LENGTH    = 4'd1;
  localparam logic [3:0] ERR_VERSION   = 4'd2;
  localparam logic [3:0] ERR_FIELD_LEN = 4'd3;
  localparam logic [3:0] ERR_ZERO_ID   = 4'd4;
  localparam logic [3:0] ERR_GRANT     = 4'd5;
  localparam logic [3:0] ERR_TICKET    = 4'd6;
  localparam logic [3:0] ERR_ROUTE     = 4'd7;
  localparam logic [3:0] ERR_TLS       = 4'd8;
  localparam logic [3:0] ERR_AUDIENCE  = 4'd9;

  localparam logic [7:0] VERSION_ONE = 8'd1;

  // Character codes
  localparam logic [7:0] CHAR_DOT   = 8'h2E;
  localparam logic [7:0] CHAR_DASH  = 8'h2D;
  localparam logic [7:0] CHAR_UNDER = 8'h5F;
  localparam logic [7:0] CHAR_LC_A  = 8'h61;
  localparam logic [7:0] CHAR_LC_Z  = 8'h7A;
  localparam logic [7:0] CHAR_UC_A  = 8'h41;
  localparam logic [7:0] CHAR_UC_Z  = 8'h5A;
  localparam logic [7:0] CHAR_0     = 8'h30;
  localparam logic [7:0] CHAR_9     = 8'h39;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last;
  } gmv_in_t;

  typedef struct packed {
    logic [7:0]  byte_out;
    logic [3:0]  region;
    logic        done_res;
    logic        accept;
    logic [3:0]  error_code;
    logic [15:0] route_port_out;
    logic [15:0] tls_port_out;
    logic [31:0] server_id_out;
    logic [63:0] expiry_out;
    logic [7:0]  route_length_out;
    logic [7:0]  tls_length_out;
    logic [7:0]  audience_length_out;
  } gmv_out_t;

endpackage

[rtl/core/gmv_stream_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gmv_stream_if: valid/ready stream channel
// Carries one payload per request; a request moves when valid and ready are high.
// ----------------------------------------------------------------------------
interface gmv_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

[rtl/core/grant_message_validator.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grant_message_validator: byte-stream grant message checker
// Tags each message byte with its region and checks the whole message.
// ----------------------------------------------------------------------------
// Usage:
//   in_i carries one message byte per request (data_byte, last). out_o carries
//   one result per byte: the echoed byte, its region tag and, on the byte
//   marked last, done_res, accept, the first error code and decoded fields.
//   A byte waits in the input register; its result is registered into the
//   result register when that is free, and out_o offers it from there.
//   Throughput is one byte per cycle unless out_o stalls: the checks are compares
//   and counter updates done in one pass between the input and result registers.
//   When the receiver stalls, the pending result holds and the input register
//   still takes one more byte; after that in_i.ready drops until out_o drains.
//   Reset clears the message state and both valid flags; after the last byte
//   of a message the state returns to its reset value for the next message.
// ----------------------------------------------------------------------------
module grant_message_validator #(
  parameter int unsigned TICKET_BYTES   = gmv_pkg::TICKET_BYTES_DEF,
  parameter int unsigned HEADER_BYTES   = gmv_pkg::HEADER_BYTES_DEF,
  parameter int unsigned ROUTE_HOST_MAX = gmv_pkg::ROUTE_HOST_MAX_DEF,
  parameter int unsigned TLS_HOST_MAX   = gmv_pkg::TLS_HOST_MAX_DEF,
  parameter int unsigned AUDIENCE_MAX   = gmv_pkg::AUDIENCE_MAX_DEF,
  parameter int unsigned MESSAGE_MAX    = gmv_pkg::MESSAGE_MAX_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  gmv_stream_if.sink    in_i,
  gmv_stream_if.source  out_o
);

  localparam int unsigned TICKET_END_I =
      (gmv_pkg::TICKET_START + TICKET_BYTES > HEADER_BYTES) ?
      HEADER_BYTES : gmv_pkg::TICKET_START + TICKET_BYTES;
  localparam int unsigned PW = gmv_pkg::POS_W;
  localparam logic [PW-1:0] TICKET_END  = PW'(TICKET_END_I);
  localparam logic [PW-1:0] R_START     = PW'(HEADER_BYTES);
  localparam logic [PW-1:0] GRANT_POS   = PW'(gmv_pkg::GRANT_START);
  localparam logic [PW-1:0] TICKET_POS  = PW'(gmv_pkg::TICKET_START);
  localparam logic [PW-1:0] MSG_MAX     = PW'(MESSAGE_MAX);
  localparam logic [7:0]    ROUTE_MAX_L = 8'(ROUTE_HOST_MAX);
  localparam logic [7:0]    TLS_MAX_L   = 8'(TLS_HOST_MAX);
  localparam logic [7:0]    AUD_MAX_L   = 8'(AUDIENCE_MAX);

  // Input register
  logic       s1_valid_q;
  logic [7:0] s1_byte_q;
  logic       s1_last_q;
  logic       advance;

  // Result register
  logic             out_valid_q;
  gmv_pkg::gmv_out_t out_q;
  gmv_pkg::gmv_out_t res;

  // Message state
  logic [gmv_pkg::CNT_W-1:0] count_q, count_d, count_inc;
  logic [7:0]  version_q, version_d;
  logic [7:0]  len_q [3];
  logic [7:0]  len_d [3];
  logic [15:0] port0_q, port0_d, port1_q, port1_d;
  logic [31:0] server_q, server_d;
  logic [63:0] expiry_q, expiry_d;
  logic [1:0]  nonzero_q, nonzero_d;
  logic [6:0]  label_q, label_d;
  logic [7:0]  prev_q, prev_d;
  logic [2:0]  fail_q, fail_d;

  // Datapath
  logic [PW-1:0] pos, pos_p1, t_start, a_start, a_end, len_sum;
  logic [3:0]    region;
  logic [3:0]    code;
  logic [7:0]    b;
  logic          dns_active, dns_first, dns_final, dns_bad;
  logic [6:0]    lab_in, lab_nx;
  logic          is_lower, is_upper, is_digit, is_dash, is_dot;

  assign advance       = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready    = !s1_valid_q || advance;
  assign out_o.valid   = out_valid_q;
  assign out_o.payload = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.valid && in_i.ready) begin
      s1_valid_q <= 1'b1;
    end else if (advance) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      s1_byte_q <= in_i.payload.data_byte;
      s1_last_q <= in_i.payload.last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= res;
    end
  end

  assign b         = s1_byte_q;
  assign pos       = {1'b0, count_q};
  assign pos_p1    = pos + PW'(1);
  assign count_inc = (count_q == gmv_pkg::COUNT_TOP) ? count_q : count_q + 1'b1;

  assign is_lower = (b >= gmv_pkg::CHAR_LC_A) && (b <= gmv_pkg::CHAR_LC_Z);
  assign is_upper = (b >= gmv_pkg::CHAR_UC_A) && (b <= gmv_pkg::CHAR_UC_Z);
  assign is_digit = (b >= gmv_pkg::CHAR_0) && (b <= gmv_pkg::CHAR_9);
  assign is_dash  = (b == gmv_pkg::CHAR_DASH);
  assign is_dot   = (b == gmv_pkg::CHAR_DOT);

  // Header capture
  always_comb begin
    version_d = version_q;
    len_d     = len_q;
    port0_d   = port0_q;
    port1_d   = port1_q;
    server_d  = server_q;
    expiry_d  = expiry_q;
    if (pos == PW'(0)) begin
      version_d = b;
    end else if (pos <= PW'(3)) begin
      len_d[2'(pos - PW'(1))] = b;
    end else if (pos <= PW'(5)) begin
      port0_d = {port0_q[7:0], b};
    end else if (pos <= PW'(7)) begin
      port1_d = {port1_q[7:0], b};
    end else if (pos <= PW'(11)) begin
      server_d = {server_q[23:0], b};
    end else if (pos <= PW'(19)) begin
      expiry_d = {expiry_q[55:0], b};
    end
  end

  assign t_start = R_START + {4'b0, len_d[0]};
  assign a_start = t_start + {4'b0, len_d[1]};
  assign a_end   = a_start + {4'b0, len_d[2]};

  always_comb begin
    if (pos <= PW'(3))          region = gmv_pkg::RGN_HEAD;
    else if (pos <= PW'(11))    region = gmv_pkg::RGN_PORTS;
    else if (pos < GRANT_POS)   region = gmv_pkg::RGN_EXPIRY;
    else if (pos < TICKET_POS)  region = gmv_pkg::RGN_GRANT;
    else if (pos < TICKET_END)  region = gmv_pkg::RGN_TICKET;
    else if (pos < R_START)     region = gmv_pkg::RGN_PAD;
    else if (pos < t_start)     region = gmv_pkg::RGN_ROUTE;
    else if (pos < a_start)     region = gmv_pkg::RGN_TLS;
    else if (pos < a_end)       region = gmv_pkg::RGN_AUDIENCE;
    else                        region = gmv_pkg::RGN_EXCESS;
  end

  // Running host name check, shared by both host strings
  assign dns_active = (region == gmv_pkg::RGN_ROUTE) || (region == gmv_pkg::RGN_TLS);
  assign dns_first  = (region == gmv_pkg::RGN_ROUTE) ? (pos == R_START) : (pos == t_start);
  assign dns_final  = (region == gmv_pkg::RGN_ROUTE) ? (pos_p1 == t_start)
                                                     : (pos_p1 == a_start);
  assign lab_in     = dns_first ? 7'd0 : label_q;

  always_comb begin
    dns_bad = 1'b0;
    lab_nx  = lab_in;
    if (is_dot) begin
      dns_bad = (lab_in == 7'd0) ||
                (!dns_first && (prev_q == gmv_pkg::CHAR_DASH));
      lab_nx  = 7'd0;
    end else begin
      if (!is_lower && !is_digit && !is_dash) dns_bad = 1'b1;
      if ((lab_in == 7'd0) && is_dash)        dns_bad = 1'b1;
      if (lab_in <= gmv_pkg::LABEL_TOP)       lab_nx = lab_in + 7'd1;
      if (lab_nx > gmv_pkg::LABEL_TOP)        dns_bad = 1'b1;
    end
    if (dns_final && ((lab_nx == 7'd0) || is_dash)) dns_bad = 1'b1;
  end

  // Flags after this byte
  always_comb begin
    nonzero_d = nonzero_q;
    fail_d    = fail_q;
    label_d   = label_q;
    prev_d    = prev_q;
    if ((region == gmv_pkg::RGN_GRANT) && (b != 8'd0))  nonzero_d[0] = 1'b1;
    if ((region == gmv_pkg::RGN_TICKET) && (b != 8'd0)) nonzero_d[1] = 1'b1;
    if (dns_active) begin
      label_d = lab_nx;
      prev_d  = b;
      if (dns_bad) begin
        if (region == gmv_pkg::RGN_ROUTE) fail_d[0] = 1'b1;
        else                              fail_d[1] = 1'b1;
      end
    end
    if ((region == gmv_pkg::RGN_AUDIENCE) &&
        !(is_lower || is_upper || is_digit || is_dot || is_dash ||
          (b == gmv_pkg::CHAR_UNDER))) begin
      fail_d[2] = 1'b1;
    end
  end

  assign len_sum = {4'b0, len_d[0]} + {4'b0, len_d[1]} + {4'b0, len_d[2]} + R_START;

  // First failing check wins
  always_comb begin
    if ({1'b0, count_inc} > MSG_MAX)             code = gmv_pkg::ERR_LENGTH;
    else if (version_d != gmv_pkg::VERSION_ONE)  code = gmv_pkg::ERR_VERSION;
    else if ((len_d[0] == 8'd0) || (len_d[0] > ROUTE_MAX_L) ||
             (len_d[1] == 8'd0) || (len_d[1] > TLS_MAX_L) ||
             (len_d[2] == 8'd0) || (len_d[2] > AUD_MAX_L) ||
             (len_sum > MSG_MAX))                code = gmv_pkg::ERR_FIELD_LEN;
    else if ({1'b0, count_inc} != len_sum)       code = gmv_pkg::ERR_LENGTH;
    else if ((port0_d == 16'd0) || (port1_d == 16'd0) ||
             (server_d == 32'd0))                code = gmv_pkg::ERR_ZERO_ID;
    else if (!nonzero_d[0])                      code = gmv_pkg::ERR_GRANT;
    else if (!nonzero_d[1])                      code = gmv_pkg::ERR_TICKET;
    else if (fail_d[0])                          code = gmv_pkg::ERR_ROUTE;
    else if (fail_d[1])                          code = gmv_pkg::ERR_TLS;
    else if (fail_d[2])                          code = gmv_pkg::ERR_AUDIENCE;
    else                                         code = gmv_pkg::ERR_OK;
  end

  always_comb begin
    res          = '0;
    res.byte_out = b;
    res.region   = region;
    if (s1_last_q) begin
      res.done_res            = 1'b1;
      res.accept              = (code == gmv_pkg::ERR_OK);
      res.error_code          = code;
      res.route_port_out      = port0_d;
      res.tls_port_out        = port1_d;
      res.server_id_out       = server_d;
      res.expiry_out          = expiry_d;
      res.route_length_out    = len_d[0];
      res.tls_length_out      = len_d[1];
      res.audience_length_out = len_d[2];
    end
  end

  assign count_d = count_inc;

  // Advance message state; drop it after the last byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      version_q <= '0;
      len_q     <= '{default: '0};
      port0_q   <= '0;
      port1_q   <= '0;
      server_q  <= '0;
      expiry_q  <= '0;
      nonzero_q <= '0;
      label_q   <= '0;
      prev_q    <= '0;
      fail_q    <= '0;
    end else if (advance) begin
      if (s1_last_q) begin
        count_q   <= '0;
        version_q <= '0;
        len_q     <= '{default: '0};
        port0_q   <= '0;
        port1_q   <= '0;
        server_q  <= '0;
        expiry_q  <= '0;
        nonzero_q <= '0;
        label_q   <= '0;
        prev_q    <= '0;
        fail_q    <= '0;
      end else begin
        count_q   <= count_d;
        version_q <= version_d;
        len_q     <= len_d;
        port0_q   <= port0_d;
        port1_q   <= port1_d;
        server_q  <= server_d;
        expiry_q  <= expiry_d;
        nonzero_q <= nonzero_d;
        label_q   <= label_d;
        prev_q    <= prev_d;
        fail_q    <= fail_d;
      end
    end
  end

endmodule

[tb/grant_message_validator_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grant_message_validator_test: self-checking bench for the grant validator
// Streams short directed messages, then random grant messages (well formed,
// flawed, truncated and noise) through the valid/ready channels with random
// idling and one long output hold-off. A scoreboard predicts every echoed
// byte, region tag and end-of-message verdict.
// ----------------------------------------------------------------------------
module grant_message_validator_test;
  import gmv_pkg::*;

  localparam int unsigned RANDOM_REQUESTS = 1000;
  localparam int unsigned QUIET_LIMIT     = 5000;
  localparam int unsigned HOLD_CYCLES     = 200;
  localparam int unsigned TAIL_CYCLES     = 10;

  typedef bit [7:0] byte_q_t[$];

  typedef enum int {
    FLAW_NONE,
    FLAW_VERSION,
    FLAW_LEN_ZERO,
    FLAW_LEN_BIG,
    FLAW_TRUNCATE,
    FLAW_EXCESS,
    FLAW_ZERO_PORT,
    FLAW_ZERO_SERVER,
    FLAW_ZERO_GRANT,
    FLAW_ZERO_TICKET,
    FLAW_ROUTE,
    FLAW_TLS,
    FLAW_AUDIENCE,
    FLAW_COUNT
  } flaw_e;

  class grant_scoreboard;
    gmv_out_t    expected_results[$];
    int unsigned failures;

    bit [10:0] byte_count;
    bit [7:0]  version_byte;
    bit [7:0]  field_len[3];
    bit [15:0] route_port;
    bit [15:0] tls_port;
    bit [31:0] server_id;
    bit [63:0] expiry;
    bit        grant_seen;
    bit        ticket_seen;
    bit [6:0]  label_len;
    bit [7:0]  prev_byte;
    bit        route_bad;
    bit        tls_bad;
    bit        audience_bad;

    function new();
      failures = 0;
      clear_message();
    endfunction

    function void clear_message();
      byte_count   = '0;
      version_byte = '0;
      field_len    = '{default: '0};
      route_port   = '0;
      tls_port     = '0;
      server_id    = '0;
      expiry       = '0;
      grant_seen   = 1'b0;
      ticket_seen  = 1'b0;
      label_len    = '0;
      prev_byte    = '0;
      route_bad    = 1'b0;
      tls_bad      = 1'b0;
      audience_bad = 1'b0;
    endfunction

    // Advance the running label check of a host name by one byte.
    function bit host_byte_bad(bit [7:0] b, bit first, bit final_byte);
      int unsigned lab;
      bit          bad;
      lab = first ? 0 : label_len;
      bad = 1'b0;
      if (b == CHAR_DOT) begin
        if (lab == 0 || (!first && prev_byte == CHAR_DASH)) bad = 1'b1;
        lab = 0;
      end else begin
        if (!(b >= CHAR_LC_A && b <= CHAR_LC_Z) && !(b >= CHAR_0 && b <= CHAR_9) &&
            b != CHAR_DASH) bad = 1'b1;
        if (lab == 0 && b == CHAR_DASH) bad = 1'b1;
        if (lab <= LABEL_TOP) lab++;
        if (lab > LABEL_TOP) bad = 1'b1;
      end
      if (final_byte && (lab == 0 || b == CHAR_DASH)) bad = 1'b1;
      label_len = lab[6:0];
      prev_byte = b;
      return bad;
    endfunction

    function void note_request(gmv_in_t req);
      int unsigned pos, ticket_end, t_start, a_start, a_end, total, r, t, a;
      bit [7:0]    b;
      bit [3:0]    rgn;
      bit [3:0]    code;
      gmv_out_t    res;
      b   = req.data_byte;
      pos = byte_count;
      ticket_end = TICKET_START + TICKET_BYTES_DEF;
      if (ticket_end > HEADER_BYTES_DEF) ticket_end = HEADER_BYTES_DEF;

      if (pos == 0) version_byte = b;
      else if (pos <= 3) field_len[pos-1] = b;
      else if (pos <= 5) route_port = {route_port[7:0], b};
      else if (pos <= 7) tls_port = {tls_port[7:0], b};
      else if (pos <= 11) server_id = {server_id[23:0], b};
      else if (pos <= 19) expiry = {expiry[55:0], b};

      t_start = HEADER_BYTES_DEF + field_len[0];
      a_start = t_start + field_len[1];
      a_end   = a_start + field_len[2];

      if (pos <= 3) rgn = RGN_HEAD;
      else if (pos <= 11) rgn = RGN_PORTS;
      else if (pos < GRANT_START) rgn = RGN_EXPIRY;
      else if (pos < TICKET_START) rgn = RGN_GRANT;
      else if (pos < ticket_end) rgn = RGN_TICKET;
      else if (pos < HEADER_BYTES_DEF) rgn = RGN_PAD;
      else if (pos < t_start) rgn = RGN_ROUTE;
      else if (pos < a_start) rgn = RGN_TLS;
      else if (pos < a_end) rgn = RGN_AUDIENCE;
      else rgn = RGN_EXCESS;

      case (rgn)
        RGN_GRANT: if (b != 8'd0) grant_seen = 1'b1;
        RGN_TICKET: if (b != 8'd0) ticket_seen = 1'b1;
        RGN_ROUTE: begin
          if (host_byte_bad(b, pos == HEADER_BYTES_DEF, pos + 1 == t_start)) route_bad = 1'b1;
        end
        RGN_TLS: begin
          if (host_byte_bad(b, pos == t_start, pos + 1 == a_start)) tls_bad = 1'b1;
        end
        RGN_AUDIENCE: begin
          if (!((b >= CHAR_LC_A && b <= CHAR_LC_Z) || (b >= CHAR_UC_A && b <= CHAR_UC_Z) ||
                (b >= CHAR_0 && b <= CHAR_9) || b == CHAR_DOT || b == CHAR_UNDER ||
                b == CHAR_DASH)) audience_bad = 1'b1;
        end
        default: ;
      endcase

      if (byte_count != COUNT_TOP) byte_count++;

      res = '0;
      res.byte_out = b;
      res.region   = rgn;
      if (req.last) begin
        total = byte_count;
        r = field_len[0];
        t = field_len[1];
        a = field_len[2];
        code = ERR_OK;
        if (total > MESSAGE_MAX_DEF) code = ERR_LENGTH;
        else if (version_byte != VERSION_ONE) code = ERR_VERSION;
        else if (r == 0 || r > ROUTE_HOST_MAX_DEF || t == 0 || t > TLS_HOST_MAX_DEF ||
                 a == 0 || a > AUDIENCE_MAX_DEF ||
                 r + t + a + HEADER_BYTES_DEF > MESSAGE_MAX_DEF) code = ERR_FIELD_LEN;
        else if (total != HEADER_BYTES_DEF + r + t + a) code = ERR_LENGTH;
        else if (route_port == 0 || tls_port == 0 || server_id == 0) code = ERR_ZERO_ID;
        else if (!grant_seen) code = ERR_GRANT;
        else if (!ticket_seen) code = ERR_TICKET;
        else if (route_bad) code = ERR_ROUTE;
        else if (tls_bad) code = ERR_TLS;
        else if (audience_bad) code = ERR_AUDIENCE;
        res.done_res            = 1'b1;
        res.accept              = (code == ERR_OK);
        res.error_code          = code;
        res.route_port_out      = route_port;
        res.tls_port_out        = tls_port;
        res.server_id_out       = server_id;
        res.expiry_out          = expiry;
        res.route_length_out    = field_len[0];
        res.tls_length_out      = field_len[1];
        res.audience_length_out = field_len[2];
        clear_message();
      end
      expected_results.push_back(res);
    endfunction

    function void compare_field(string name, bit [63:0] want, logic [63:0] got);
      if (got !== want) begin
        $error("%s: expected %0h, actual %0h", name, want, got);
        failures++;
      end
    endfunction

    function void check_result(gmv_out_t got);
      gmv_out_t want;
      if (expected_results.size() == 0) begin
        $error("result with no pending request: byte_out %0h", got.byte_out);
        failures++;
        return;
      end
      want = expected_results.pop_front();
      compare_field("byte_out", want.byte_out, got.byte_out);
      compare_field("region", want.region, got.region);
      compare_field("done_res", want.done_res, got.done_res);
      compare_field("accept", want.accept, got.accept);
      compare_field("error_code", want.error_code, got.error_code);
      compare_field("route_port_out", want.route_port_out, got.route_port_out);
      compare_field("tls_port_out", want.tls_port_out, got.tls_port_out);
      compare_field("server_id_out", want.server_id_out, got.server_id_out);
      compare_field("expiry_out", want.expiry_out, got.expiry_out);
      compare_field("route_length_out", want.route_length_out, got.route_length_out);
      compare_field("tls_length_out", want.tls_length_out, got.tls_length_out);
      compare_field("audience_length_out", want.audience_length_out,
                    got.audience_length_out);
    endfunction
  endclass

  logic clk;
  logic rst_n;

  gmv_stream_if #(.payload_t(gmv_in_t))  in_if ();
  gmv_stream_if #(.payload_t(gmv_out_t)) out_if ();

  grant_message_validator dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  grant_scoreboard board = new();

  int unsigned tx_idle_pct;
  int unsigned rx_idle_pct;
  int unsigned requests_sent;
  int unsigned quiet_cycles;
  int unsigned hold_left;
  bit          backpressure_req;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic bit [7:0] pick_alnum();
    int unsigned r;
    r = $urandom_range(35);
    return (r < 26) ? CHAR_LC_A + 8'(r) : CHAR_0 + 8'(r - 26);
  endfunction

  // Build a canonical host name; plain names are a single label.
  function automatic byte_q_t make_host(int unsigned n, bit plain);
    byte_q_t     h;
    int unsigned lab;
    int unsigned sel;
    bit [7:0]    c;
    bit [7:0]    prev;
    lab  = 0;
    prev = CHAR_DOT;
    for (int unsigned i = 0; i < n; i++) begin
      if (plain || prev == CHAR_DOT) begin
        c = pick_alnum();
      end else if (lab >= 60) begin
        c = (prev != CHAR_DASH && i < n - 1) ? CHAR_DOT : pick_alnum();
      end else begin
        sel = $urandom_range(7);
        if (sel == 0 && prev != CHAR_DASH && i < n - 1) c = CHAR_DOT;
        else if (sel == 1 && i < n - 1) c = CHAR_DASH;
        else c = pick_alnum();
      end
      lab = (c == CHAR_DOT) ? 0 : lab + 1;
      h.push_back(c);
      prev = c;
    end
    return h;
  endfunction

  function automatic void break_host(ref byte_q_t h);
    int unsigned n, k;
    n = h.size();
    k = $urandom_range(n - 1);
    case ($urandom_range(5))
      0: h[k] = 8'($urandom_range(255));
      1: h[0] = CHAR_DASH;
      2: h[n-1] = $urandom_range(1) ? CHAR_DOT : CHAR_DASH;
      3: h[k] = CHAR_UC_A + 8'($urandom_range(25));
      4: begin
        // empty label
        if (n < 2) h[0] = CHAR_DOT;
        else begin
          k = $urandom_range(n - 2);
          h[k] = CHAR_DOT;
          h[k+1] = CHAR_DOT;
        end
      end
      default: begin
        // dash closing a label
        if (n < 2) h[0] = CHAR_DASH;
        else begin
          k = $urandom_range(n - 2);
          h[k] = CHAR_DASH;
          h[k+1] = CHAR_DOT;
        end
      end
    endcase
  endfunction

  function automatic int unsigned pick_host_len(output bit plain);
    int unsigned sel;
    sel   = $urandom_range(39);
    plain = 1'b0;
    if (sel == 0) return ROUTE_HOST_MAX_DEF;
    if (sel < 5) begin
      // single label around the 63-byte label limit
      plain = 1'b1;
      return $urandom_range(66, 62);
    end
    return $urandom_range(12, 1);
  endfunction

  function automatic byte_q_t build_grant(bit allow_flaw);
    byte_q_t     msg, route, tls;
    flaw_e       flaw;
    int unsigned r, t, a, k, cut;
    bit          plain;
    bit [15:0]   rport, tport;
    bit [31:0]   sid;
    bit [63:0]   expiry_ms;
    bit [7:0]    c;

    flaw = flaw_e'($urandom_range(FLAW_COUNT - 1));
    if (!allow_flaw || $urandom_range(9) < 4) flaw = FLAW_NONE;

    r = pick_host_len(plain);
    route = make_host(r, plain);
    t = pick_host_len(plain);
    tls = make_host(t, plain);
    a = ($urandom_range(19) == 0) ? AUDIENCE_MAX_DEF : $urandom_range(8, 1);

    rport = 16'($urandom_range(65535, 1));
    tport = 16'($urandom_range(65535, 1));
    sid = $urandom();
    if (sid == 0) sid = 32'd1;
    expiry_ms = {$urandom(), $urandom()};
    if (flaw == FLAW_ZERO_PORT) begin
      if ($urandom_range(1)) rport = '0;
      else tport = '0;
    end
    if (flaw == FLAW_ZERO_SERVER) sid = '0;
    if (flaw == FLAW_ROUTE) break_host(route);
    if (flaw == FLAW_TLS) break_host(tls);

    msg = '{VERSION_ONE, 8'(r), 8'(t), 8'(a), rport[15:8], rport[7:0], tport[15:8], tport[7:0],
            sid[31:24], sid[23:16], sid[15:8], sid[7:0]};
    for (int i = 7; i >= 0; i--) msg.push_back(expiry_ms[8*i +: 8]);
    for (int unsigned i = GRANT_START; i < TICKET_START; i++) begin
      msg.push_back((flaw == FLAW_ZERO_GRANT) ? 8'd0 : 8'($urandom_range(255)));
    end
    for (int unsigned i = 0; i < TICKET_BYTES_DEF; i++) begin
      msg.push_back((flaw == FLAW_ZERO_TICKET) ? 8'd0 : 8'($urandom_range(255)));
    end
    while (msg.size() < HEADER_BYTES_DEF) msg.push_back(8'($urandom_range(255)));
    msg = {msg, route, tls};
    for (int unsigned i = 0; i < a; i++) begin
      k = $urandom_range(64);
      if (k < 26) c = CHAR_LC_A + 8'(k);
      else if (k < 52) c = CHAR_UC_A + 8'(k - 26);
      else if (k < 62) c = CHAR_0 + 8'(k - 52);
      else if (k == 62) c = CHAR_DOT;
      else if (k == 63) c = CHAR_UNDER;
      else c = CHAR_DASH;
      msg.push_back(c);
    end

    case (flaw)
      FLAW_VERSION: begin
        do c = 8'($urandom_range(255)); while (c == VERSION_ONE);
        msg[0] = c;
      end
      FLAW_LEN_ZERO: msg[1 + $urandom_range(2)] = 8'd0;
      FLAW_LEN_BIG: begin
        k = $urandom_range(2);
        msg[1+k] = (k < 2) ? 8'($urandom_range(255, ROUTE_HOST_MAX_DEF + 1)) :
                             8'($urandom_range(255, AUDIENCE_MAX_DEF + 1));
      end
      FLAW_TRUNCATE: begin
        cut = $urandom_range(msg.size() - 1, 1);
        msg = msg[0:cut-1];
      end
      FLAW_EXCESS: repeat ($urandom_range(5, 1)) msg.push_back(8'($urandom_range(255)));
      FLAW_AUDIENCE: begin
        do c = 8'($urandom_range(255));
        while ((c >= CHAR_LC_A && c <= CHAR_LC_Z) || (c >= CHAR_UC_A && c <= CHAR_UC_Z) ||
               (c >= CHAR_0 && c <= CHAR_9) || c == CHAR_DOT || c == CHAR_UNDER ||
               c == CHAR_DASH);
        msg[msg.size() - 1 - $urandom_range(a - 1)] = c;
      end
      default: ;
    endcase
    return msg;
  endfunction

  function automatic byte_q_t build_noise();
    byte_q_t msg;
    repeat ($urandom_range(30, 1)) msg.push_back(8'($urandom_range(255)));
    if ($urandom_range(1)) msg[0] = VERSION_ONE;
    return msg;
  endfunction

  task automatic send_request(input bit [7:0] b, input bit last);
    gmv_in_t req;
    req = '{data_byte: b, last: last};
    @(negedge clk);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_if.valid <= 1'b0;
      @(negedge clk);
    end
    in_if.payload <= req;
    in_if.valid   <= 1'b1;
    do @(posedge clk); while (!in_if.ready);
    board.note_request(req);
    requests_sent++;
  endtask

  task automatic send_message(input byte_q_t msg);
    foreach (msg[i]) send_request(msg[i], i == msg.size() - 1);
  endtask

  // Receiver: random stalls, plus one long hold-off on request.
  initial begin
    out_if.ready = 1'b0;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (backpressure_req) begin
        backpressure_req = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready) board.check_result(out_if.payload);
  end

  always @(posedge clk) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) quiet_cycles = 0;
    else if (rst_n) quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    byte_q_t     msg;
    int unsigned directed_count;
    rst_n            = 1'b0;
    in_if.valid      = 1'b0;
    in_if.payload    = '0;
    tx_idle_pct      = 9;
    rx_idle_pct      = 61;
    requests_sent    = 0;
    quiet_cycles     = 0;
    backpressure_req = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Short messages: bad version, zero lengths, short header, max decode values.
    msg = '{8'h00};
    send_message(msg);
    msg = '{8'h01};
    send_message(msg);
    msg = '{8'hFF};
    send_message(msg);
    msg = '{8'h01, 8'h05, 8'h05, 8'h05};
    send_message(msg);
    msg = '{8'h01, 8'h01, 8'h01, 8'h40};
    send_message(msg);
    msg = '{8'h01, 8'hFF, 8'h01, 8'h01, 8'hFF, 8'hFF, 8'h00, 8'h01, 8'h80, 8'h00, 8'h00, 8'h00};
    send_message(msg);
    directed_count = requests_sent;

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          tx_idle_pct = 9;
          rx_idle_pct = 61;
        end
        1: begin
          tx_idle_pct = 61;
          rx_idle_pct = 9;
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
          backpressure_req = 1'b1;
        end
      endcase
      while (requests_sent < directed_count + RANDOM_REQUESTS * (phase + 1) / 3) begin
        if ($urandom_range(9) < 7) send_message(build_grant(1'b1));
        else send_message(build_noise());
      end
    end

    @(negedge clk);
    in_if.valid <= 1'b0;
    while (board.expected_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (board.failures == 0 && board.expected_results.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
